>>> rtl/llpf_pkg.sv
package llpf_pkg;

  localparam int PointW     = 9;
  localparam int PointInW   = 11;
  localparam int SlopeInW   = 16;
  localparam int PointWorkW = 13;
  localparam int CountW     = 3;
  localparam int DriftW     = 6;
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = 9;

  localparam logic [PointW-1:0] CenterPoint = 9'd160;

  localparam logic [CountW-1:0] LossFramesRst   = 3'd5;
  localparam logic [CountW-1:0] RegainFramesRst = 3'd5;
  localparam logic [PointW-1:0] JumpLimitRst    = 9'd120;
  localparam logic [PointW-1:0] LeftEdgeRst     = 9'd80;
  localparam logic [PointW-1:0] RightEdgeRst    = 9'd240;
  localparam logic [DriftW-1:0] DriftStepRst    = 6'd5;
  localparam logic [PointW-1:0] PointMaxRst     = 9'd320;

  typedef enum logic [1:0] {
    TRACK_LOST     = 2'd0,
    TRACK_FOLLOW   = 2'd1,
    TRACK_REGAINED = 2'd2
  } track_mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_LOSS_FRAMES   = 3'd0,
    CFG_REGAIN_FRAMES = 3'd1,
    CFG_JUMP_LIMIT    = 3'd2,
    CFG_LEFT_EDGE     = 3'd3,
    CFG_RIGHT_EDGE    = 3'd4,
    CFG_DRIFT_STEP    = 3'd5,
    CFG_POINT_MAX     = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic [CountW-1:0] loss_frames;
    logic [CountW-1:0] regain_frames;
    logic [PointW-1:0] jump_limit;
    logic [PointW-1:0] left_edge;
    logic [PointW-1:0] right_edge;
    logic [DriftW-1:0] drift_step;
    logic [PointW-1:0] point_max;
  } cfg_t;

endpackage

>>> rtl/line_loss_point_filter_top.sv
// Line loss point filter: takes camera frame transactions (point, slope, car-stopped
// flag) and returns one filtered transaction per frame with the tracker state. A
// frame passes an input register, then a single pass of compare and select logic into
// the result register. Throughput is one transaction per cycle unless the output
// stalls; the tracker counters and the held point and slope update in the same cycle
// that a frame moves into the result register, so the next frame sees them at once.
// The result register lets a new frame enter while a finished one still waits.
// Configuration registers are written by index and take effect on the next frame.
module line_loss_point_filter_top #(
  parameter int SLOPE_FRAC_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [llpf_pkg::CfgIndexW-1:0]        cfg_index_i,
  input  logic [llpf_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [llpf_pkg::PointInW-1:0]  point_in_i,
  input  logic signed [llpf_pkg::SlopeInW-1:0]  slope_in_i,
  input  logic                                  car_stopped_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [llpf_pkg::PointW-1:0]           point_out_o,
  output logic signed [SLOPE_FRAC_BITS+1:0]     slope_out_o,
  output logic [1:0]                            track_state_o
);

  llpf_pkg::cfg_t        cfg;
  llpf_pkg::track_mode_e mode_d;

  logic                                  in_valid_q, out_valid_q, advance, line;
  logic signed [llpf_pkg::PointInW-1:0]  point_q;
  logic signed [llpf_pkg::SlopeInW-1:0]  slope_q;
  logic                                  stopped_q;
  logic [llpf_pkg::PointW-1:0]           point_d, point_out_q;
  logic signed [SLOPE_FRAC_BITS+1:0]     slope_d, slope_out_q;
  llpf_pkg::track_mode_e                 state_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign line       = (point_q != '1);

  llpf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  llpf_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .line_i (line),
    .cfg_i  (cfg),
    .mode_o (mode_d)
  );

  llpf_filter #(
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .line_i    (line),
    .point_i   (point_q),
    .slope_i   (slope_q),
    .stopped_i (stopped_q),
    .mode_i    (mode_d),
    .cfg_i     (cfg),
    .point_o   (point_d),
    .slope_o   (slope_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      point_q   <= point_in_i;
      slope_q   <= slope_in_i;
      stopped_q <= car_stopped_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      point_out_q <= point_d;
      slope_out_q <= slope_d;
      state_q     <= mode_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_out_o   = point_out_q;
  assign slope_out_o   = slope_out_q;
  assign track_state_o = state_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(point_q) && $stable(slope_q))
    else $error("stalled frame dropped from input register");

endmodule

>>> rtl/llpf_cfg.sv
module llpf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [llpf_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [llpf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output llpf_pkg::cfg_t                  cfg_o
);

  llpf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (llpf_pkg::cfg_index_e'(cfg_index_i))
        llpf_pkg::CFG_LOSS_FRAMES:   cfg_d.loss_frames   = cfg_wdata_i[llpf_pkg::CountW-1:0];
        llpf_pkg::CFG_REGAIN_FRAMES: cfg_d.regain_frames = cfg_wdata_i[llpf_pkg::CountW-1:0];
        llpf_pkg::CFG_JUMP_LIMIT:    cfg_d.jump_limit    = cfg_wdata_i[llpf_pkg::PointW-1:0];
        llpf_pkg::CFG_LEFT_EDGE:     cfg_d.left_edge     = cfg_wdata_i[llpf_pkg::PointW-1:0];
        llpf_pkg::CFG_RIGHT_EDGE:    cfg_d.right_edge    = cfg_wdata_i[llpf_pkg::PointW-1:0];
        llpf_pkg::CFG_DRIFT_STEP:    cfg_d.drift_step    = cfg_wdata_i[llpf_pkg::DriftW-1:0];
        llpf_pkg::CFG_POINT_MAX:     cfg_d.point_max     = cfg_wdata_i[llpf_pkg::PointW-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loss_frames   <= llpf_pkg::LossFramesRst;
      cfg_q.regain_frames <= llpf_pkg::RegainFramesRst;
      cfg_q.jump_limit    <= llpf_pkg::JumpLimitRst;
      cfg_q.left_edge     <= llpf_pkg::LeftEdgeRst;
      cfg_q.right_edge    <= llpf_pkg::RightEdgeRst;
      cfg_q.drift_step    <= llpf_pkg::DriftStepRst;
      cfg_q.point_max     <= llpf_pkg::PointMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/llpf_track.sv
module llpf_track (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     line_i,
  input  llpf_pkg::cfg_t           cfg_i,
  output llpf_pkg::track_mode_e    mode_o
);

  llpf_pkg::track_mode_e mode_q, mode_d, mode_a, mode_b;
  logic [llpf_pkg::CountW-1:0] lost_count_q, lost_count_d;
  logic [llpf_pkg::CountW-1:0] found_count_q, found_count_d;
  logic [llpf_pkg::CountW:0]   lost_a, lost_b, found_a, found_b;

  // next state
  always_comb begin
    lost_a  = line_i ? '0 : {1'b0, lost_count_q};
    found_a = line_i ? {1'b0, found_count_q} : '0;
    mode_a  = (mode_q == llpf_pkg::TRACK_REGAINED && line_i) ? llpf_pkg::TRACK_FOLLOW : mode_q;
    lost_b  = (mode_a != llpf_pkg::TRACK_LOST && !line_i) ? lost_a + 4'd1 : lost_a;
    found_b = (mode_a == llpf_pkg::TRACK_LOST && line_i) ? found_a + 4'd1 : found_a;
    mode_b  = mode_a;
    if (lost_b >= {1'b0, cfg_i.loss_frames}) begin
      lost_b = '0;
      mode_b = llpf_pkg::TRACK_LOST;
    end
    mode_d = mode_b;
    if (found_b >= {1'b0, cfg_i.regain_frames}) begin
      found_b = '0;
      mode_d  = llpf_pkg::TRACK_REGAINED;
    end
    lost_count_d  = lost_b[llpf_pkg::CountW-1:0];
    found_count_d = found_b[llpf_pkg::CountW-1:0];
  end

  // outputs
  always_comb begin
    mode_o = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= llpf_pkg::TRACK_FOLLOW;
      lost_count_q  <= '0;
      found_count_q <= '0;
    end else if (en_i) begin
      mode_q        <= mode_d;
      lost_count_q  <= lost_count_d;
      found_count_q <= found_count_d;
    end
  end

  // line frames only count while lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != llpf_pkg::TRACK_LOST |-> found_count_q == '0)
    else $error("found count nonzero outside lost state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && line_i |=> lost_count_q == '0)
    else $error("lost count survived a line frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(mode_q) && $stable(lost_count_q) && $stable(found_count_q))
    else $error("tracker state moved without a transaction");

endmodule

>>> rtl/llpf_filter.sv
module llpf_filter #(
  parameter int SLOPE_FRAC_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  line_i,
  input  logic signed [llpf_pkg::PointInW-1:0]  point_i,
  input  logic signed [llpf_pkg::SlopeInW-1:0]  slope_i,
  input  logic                                  stopped_i,
  input  llpf_pkg::track_mode_e                 mode_i,
  input  llpf_pkg::cfg_t                        cfg_i,
  output logic [llpf_pkg::PointW-1:0]           point_o,
  output logic signed [SLOPE_FRAC_BITS+1:0]     slope_o
);

  localparam int SlopeW = SLOPE_FRAC_BITS + 2;
  localparam int WorkW  = (SlopeW > 17) ? SlopeW : 17;
  localparam int PW     = llpf_pkg::PointWorkW;
  localparam logic signed [WorkW-1:0] SlopeOne = {{(WorkW-1){1'b0}}, 1'b1} << SLOPE_FRAC_BITS;

  logic [llpf_pkg::PointW-1:0] held_point_q;
  logic signed [SlopeW-1:0]    held_slope_q;

  logic signed [PW-1:0] held_p, left_w, right_w, drift_w, jump_w, max_w, center_w;
  logic signed [PW-1:0] p, ref_p, diff, adiff;
  logic signed [WorkW-1:0] s, ref_s, held_s;

  assign held_p   = $signed({4'b0, held_point_q});
  assign left_w   = $signed({4'b0, cfg_i.left_edge});
  assign right_w  = $signed({4'b0, cfg_i.right_edge});
  assign drift_w  = $signed({7'b0, cfg_i.drift_step});
  assign jump_w   = $signed({4'b0, cfg_i.jump_limit});
  assign max_w    = $signed({4'b0, cfg_i.point_max});
  assign center_w = $signed({4'b0, llpf_pkg::CenterPoint});
  assign held_s   = WorkW'(held_slope_q);

  always_comb begin
    p = PW'(point_i);
    s = WorkW'(slope_i);
    if (mode_i != llpf_pkg::TRACK_LOST && !line_i) begin
      p = held_p;
      s = held_s;
    end
    if (mode_i == llpf_pkg::TRACK_LOST) begin
      if (held_p <= left_w) begin
        p = held_p - drift_w;
      end
      if (held_p >= right_w) begin
        p = held_p + drift_w;
      end
      s = '0;
    end
    ref_p = held_p;
    ref_s = held_s;
    if (mode_i == llpf_pkg::TRACK_REGAINED || stopped_i) begin
      if (p != -PW'(1)) begin
        ref_p = p;
        ref_s = s;
      end else begin
        ref_p = center_w;
        ref_s = '0;
      end
    end
    diff  = p - ref_p;
    adiff = (diff < 0) ? -diff : diff;
    if (adiff >= jump_w) begin
      p = ref_p;
      s = ref_s;
    end
    if (p >= max_w) begin
      p = max_w;
    end
    if (p <= 0) begin
      p = '0;
    end
    if (s >= SlopeOne) begin
      s = SlopeOne;
    end
    if (s <= -SlopeOne) begin
      s = -SlopeOne;
    end
    point_o = p[llpf_pkg::PointW-1:0];
    slope_o = s[SlopeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_point_q <= llpf_pkg::CenterPoint;
      held_slope_q <= '0;
    end else if (en_i) begin
      held_point_q <= point_o;
      held_slope_q <= slope_o;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |-> point_o <= cfg_i.point_max)
    else $error("point above upper clamp");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> held_point_q == $past(point_o) && held_slope_q == $past(slope_o))
    else $error("held reference differs from last result");

endmodule

>>> tb/sv/line_loss_point_filter_top_test.sv
`timescale 1ns / 1ps

module line_loss_point_filter_top_test;

  localparam int SlopeFracBits = 12;
  localparam int SlopeOne      = 1 << SlopeFracBits;
  localparam int CycleLimit    = 200000;
  localparam int LongHold      = 80;

  typedef struct packed {
    logic signed [llpf_pkg::PointInW-1:0] point;
    logic signed [llpf_pkg::SlopeInW-1:0] slope;
    logic                                 stopped;
  } frame_t;

  typedef struct packed {
    logic [llpf_pkg::PointW-1:0]     point;
    logic signed [SlopeFracBits+1:0] slope;
    llpf_pkg::track_mode_e           mode;
  } filtered_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [llpf_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [llpf_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [llpf_pkg::PointInW-1:0] point_in = '0;
  logic signed [llpf_pkg::SlopeInW-1:0] slope_in = '0;
  logic car_stopped = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [llpf_pkg::PointW-1:0] point_out;
  logic signed [SlopeFracBits+1:0] slope_out;
  logic [1:0] track_state;

  line_loss_point_filter_top #(
    .SLOPE_FRAC_BITS(SlopeFracBits)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .point_in_i   (point_in),
    .slope_in_i   (slope_in),
    .car_stopped_i(car_stopped),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .point_out_o  (point_out),
    .slope_out_o  (slope_out),
    .track_state_o(track_state)
  );

  always #5 clk = ~clk;

  // filter model state and settings
  llpf_pkg::cfg_t cfg = '{loss_frames: llpf_pkg::LossFramesRst,
                          regain_frames: llpf_pkg::RegainFramesRst,
                          jump_limit: llpf_pkg::JumpLimitRst,
                          left_edge: llpf_pkg::LeftEdgeRst,
                          right_edge: llpf_pkg::RightEdgeRst,
                          drift_step: llpf_pkg::DriftStepRst,
                          point_max: llpf_pkg::PointMaxRst};
  llpf_pkg::track_mode_e mode_now = llpf_pkg::TRACK_FOLLOW;
  int          lost_cnt = 0;
  int          found_cnt = 0;
  int          held_point = llpf_pkg::CenterPoint;
  int          held_slope = 0;

  frame_t    frame_q[$];
  filtered_t results_due[$];
  bit        frame_taken = 1'b0;
  bit        calm = 1'b0;
  int        send_gap = 0;
  int        sink_gap = 0;
  int        hold_asks = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        errors = 0;
  int        cycle_cnt = 0;

  function automatic filtered_t filter_frame(frame_t f);
    filtered_t r;
    int  p, s, ref_p, ref_s, diff;
    int  loss_thr, regain_thr, lim, ledge, redge, step, pmax;
    bit  line;
    p = f.point;
    s = f.slope;
    loss_thr = cfg.loss_frames;
    regain_thr = cfg.regain_frames;
    lim = cfg.jump_limit;
    ledge = cfg.left_edge;
    redge = cfg.right_edge;
    step = cfg.drift_step;
    pmax = cfg.point_max;
    line = (p != -1);
    ref_p = held_point;
    ref_s = held_slope;

    if (!line) found_cnt = 0;
    else lost_cnt = 0;
    if (mode_now == llpf_pkg::TRACK_REGAINED && line) mode_now = llpf_pkg::TRACK_FOLLOW;
    if (mode_now != llpf_pkg::TRACK_LOST && !line) lost_cnt++;
    if (mode_now == llpf_pkg::TRACK_LOST && line) found_cnt++;
    if (lost_cnt >= loss_thr) begin
      lost_cnt = 0;
      mode_now = llpf_pkg::TRACK_LOST;
    end
    if (found_cnt >= regain_thr) begin
      found_cnt = 0;
      mode_now = llpf_pkg::TRACK_REGAINED;
    end
    lost_cnt &= 7;
    found_cnt &= 7;

    if (mode_now != llpf_pkg::TRACK_LOST && !line) begin
      p = held_point;
      s = held_slope;
    end
    if (mode_now == llpf_pkg::TRACK_LOST) begin
      if (held_point <= ledge) p = held_point - step;
      if (held_point >= redge) p = held_point + step;
      s = 0;
    end
    if (mode_now == llpf_pkg::TRACK_REGAINED || f.stopped) begin
      if (p != -1) begin
        ref_p = p;
        ref_s = s;
      end else begin
        ref_p = llpf_pkg::CenterPoint;
        ref_s = 0;
      end
    end
    diff = p - ref_p;
    if (diff < 0) diff = -diff;
    if (diff >= lim) begin
      p = ref_p;
      s = ref_s;
    end
    if (p >= pmax) p = pmax;
    if (p <= 0) p = 0;
    if (s >= SlopeOne) s = SlopeOne;
    if (s <= -SlopeOne) s = -SlopeOne;
    held_point = p;
    held_slope = s;

    r.point = p[llpf_pkg::PointW-1:0];
    r.slope = s[SlopeFracBits+1:0];
    r.mode = mode_now;
    return r;
  endfunction

  // monitor: checks filtered transactions and predicts accepted frames
  always @(posedge clk) begin
    filtered_t got, want;
    frame_t    f;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      frame_taken = in_valid && in_ready;
      if (rst_n) begin
        if (out_valid && out_ready) begin
          got.point = point_out;
          got.slope = slope_out;
          got.mode = llpf_pkg::track_mode_e'(track_state);
          if (results_due.size() == 0) begin
            $display("%0t unexpected transaction point %0d slope %0d state %0d",
                     $time, point_out, slope_out, track_state);
            errors++;
          end else begin
            want = results_due.pop_front();
            if (got.point !== want.point) begin
              $display("%0t point_out expected %0d actual %0d", $time, want.point, got.point);
              errors++;
            end
            if (got.slope !== want.slope) begin
              $display("%0t slope_out expected %0d actual %0d", $time, want.slope, got.slope);
              errors++;
            end
            if (got.mode !== want.mode) begin
              $display("%0t track_state expected %0d actual %0d", $time, want.mode, got.mode);
              errors++;
            end
          end
        end
        if (frame_taken) begin
          f.point = point_in;
          f.slope = slope_in;
          f.stopped = car_stopped;
          results_due.push_back(filter_frame(f));
        end
      end
    end
  end

  // frame driver
  always @(negedge clk) begin
    frame_t f;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || frame_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (frame_q.size() > 0) begin
        f = frame_q.pop_front();
        in_valid <= 1'b1;
        point_in <= f.point;
        slope_in <= f.slope;
        car_stopped <= f.stopped;
        if (!calm && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink with random and long stalls
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 4);
    end
  end

  task automatic push_frame(input int p, input int s, input bit st);
    frame_t f;
    f.point = p[llpf_pkg::PointInW-1:0];
    f.slope = s[llpf_pkg::SlopeInW-1:0];
    f.stopped = st;
    frame_q.push_back(f);
  endtask

  task automatic write_reg(input llpf_pkg::cfg_index_e idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[llpf_pkg::CfgDataW-1:0];
    case (idx)
      llpf_pkg::CFG_LOSS_FRAMES:   cfg.loss_frames = val[llpf_pkg::CountW-1:0];
      llpf_pkg::CFG_REGAIN_FRAMES: cfg.regain_frames = val[llpf_pkg::CountW-1:0];
      llpf_pkg::CFG_JUMP_LIMIT:    cfg.jump_limit = val[llpf_pkg::PointW-1:0];
      llpf_pkg::CFG_LEFT_EDGE:     cfg.left_edge = val[llpf_pkg::PointW-1:0];
      llpf_pkg::CFG_RIGHT_EDGE:    cfg.right_edge = val[llpf_pkg::PointW-1:0];
      llpf_pkg::CFG_DRIFT_STEP:    cfg.drift_step = val[llpf_pkg::DriftW-1:0];
      llpf_pkg::CFG_POINT_MAX:     cfg.point_max = val[llpf_pkg::PointW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input int lf, input int rf, input int jl, input int le,
                           input int re, input int ds, input int pm);
    write_reg(llpf_pkg::CFG_LOSS_FRAMES, lf);
    write_reg(llpf_pkg::CFG_REGAIN_FRAMES, rf);
    write_reg(llpf_pkg::CFG_JUMP_LIMIT, jl);
    write_reg(llpf_pkg::CFG_LEFT_EDGE, le);
    write_reg(llpf_pkg::CFG_RIGHT_EDGE, re);
    write_reg(llpf_pkg::CFG_DRIFT_STEP, ds);
    write_reg(llpf_pkg::CFG_POINT_MAX, pm);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frame_q.size() != 0 || in_valid || results_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  // runs of line and no-line frames with a wandering column, plus raw noise
  task automatic queue_random(input int n);
    int left, run_len, base, p, s, k;
    bit gone, noise;
    left = n;
    base = $urandom_range(0, 400);
    while (left > 0) begin
      run_len = $urandom_range(1, 9);
      gone = ($urandom_range(0, 2) == 0);
      noise = ($urandom_range(0, 3) == 0);
      for (k = 0; k < run_len && left > 0; k++) begin
        if (noise) begin
          p = $urandom_range(0, 2047) - 1024;
        end else if (gone) begin
          p = -1;
        end else begin
          if ($urandom_range(0, 11) == 0) base = $urandom_range(0, 1023);
          else base = base + $urandom_range(0, 40) - 20;
          if (base < 0) base = 0;
          if (base > 1023) base = 1023;
          p = base;
        end
        case ($urandom_range(0, 3))
          0: s = SlopeOne + $urandom_range(0, 2) - 1;
          1: s = -SlopeOne + $urandom_range(0, 2) - 1;
          2: s = $urandom_range(0, 2 * SlopeOne) - SlopeOne;
          default: s = $urandom_range(0, 65535) - 32768;
        endcase
        push_frame(p, s, $urandom_range(0, 9) == 0);
        left--;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, hold, loss with left drift, regain, reseed to center
    push_frame(160, 0, 1'b0);
    push_frame(1023, 32767, 1'b0);
    push_frame(-1024, -32768, 1'b0);
    push_frame(0, SlopeOne, 1'b1);
    push_frame(100, SlopeOne - 1, 1'b0);
    push_frame(70, -SlopeOne - 1, 1'b0);
    push_frame(60, -SlopeOne, 1'b0);
    repeat (7) push_frame(-1, 1234, 1'b0);
    push_frame(-1, 0, 1'b1);
    repeat (5) push_frame(200, 300, 1'b0);
    push_frame(205, 100, 1'b0);
    repeat (5) push_frame(-1, -5, 1'b0);
    push_frame(-1, 0, 1'b1);
    wait_idle();

    queue_random(150);
    hold_asks++;
    wait_idle();

    write_all(1, 1, 511, 0, 511, 63, 511);
    queue_random(80);
    wait_idle();

    // both edges match everything: right drift wins; every jump rejected
    write_all(7, 7, 0, 511, 0, 0, 1);
    queue_random(80);
    wait_idle();

    // zero thresholds fire the transitions on every frame
    write_all(0, 0, 200, 100, 220, 17, 300);
    queue_random(60);
    wait_idle();

    write_all($urandom_range(1, 7), $urandom_range(1, 7), $urandom_range(0, 511),
              $urandom_range(0, 255), $urandom_range(200, 511), $urandom_range(0, 63),
              $urandom_range(1, 511));
    queue_random(90);
    hold_asks++;
    wait_idle();
    calm = 1'b1;
    queue_random(60);
    wait_idle();
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
